FILE: hw/rtl/tcfc_pkg.sv
// ----------------------------------------------------------------------------
// tcfc_pkg: shared definitions for the team color classifier
// Team codes, chroma weights and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfc_pkg;

   localparam int PIX_W = 15;

   localparam logic signed [PIX_W-1:0] W_BLUE_Y  = -15'sd3;
   localparam logic signed [PIX_W-1:0] W_BLUE_CB = 15'sd16;
   localparam logic signed [PIX_W-1:0] W_BLUE_CR = 15'sd3;
   localparam logic signed [PIX_W-1:0] W_RED_Y   = -15'sd1;
   localparam logic signed [PIX_W-1:0] W_RED_CB  = 15'sd2;
   localparam logic signed [PIX_W-1:0] W_RED_CR  = 15'sd16;

   localparam logic [1:0] TEAM_NONE = 2'd0;
   localparam logic [1:0] TEAM_BLUE = 2'd1;
   localparam logic [1:0] TEAM_RED  = 2'd2;

   typedef struct packed {
      logic accept;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/team_color_from_chroma_sums.sv
// ----------------------------------------------------------------------------
// team_color_from_chroma_sums: team color verdict from sampled region pixels
// Sampled YCbCr pixels of one region stream in on the request channel, row by
// row. Each request carries Y, Cb and Cr in req_tdata, has_pixel and row_end
// in req_tuser, and region_end in req_tlast. A request with region_end set
// produces one response: the team code in rsp_tdata and the overflow flag in
// rsp_tuser. Other requests produce no response.
// Requests without region_end stream in, so pixels stream at one per cycle
// while the block is taking requests. A region_end request occupies the block
// while it loads the divider, runs ACC_W steps of the one-bit-per-cycle
// restoring divider that forms the mean row difference, and then scores and
// registers the verdict.
// The verdict sits in an output register; the block returns to taking
// requests while it waits, and a new verdict is held back only while the
// previous one has not been taken.
// Synchronous reset clears the region state, the response valid flag and the request ready flag.
// ----------------------------------------------------------------------------
`default_nettype none

module team_color_from_chroma_sums #(
   parameter int MAX_ROW_SAMPLES = 64,
   parameter int MAX_ROWS        = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] pixel_luma, [15:8] pixel_blue_chroma, [23:16] pixel_red_chroma
   input  wire logic [23:0] req_tdata,
   // [0] has_pixel, [1] row_end
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] team, [7:2] zero
   output logic [7:0]       rsp_tdata,
   // [0] overflow
   output logic             rsp_tuser
);
   import tcfc_pkg::*;

   localparam int SUM_W = 14 + $clog2(MAX_ROW_SAMPLES + 1);
   localparam int ACC_W = SUM_W + 1 + $clog2(MAX_ROWS + 1);

   cmd_type    cmd;
   logic [1:0] team;

   tcfc_ctrl #(
      .DIV_STEPS (ACC_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_region_end (req_tlast),
      .req_tready     (req_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .cmd            (cmd)
   );

   tcfc_datapath #(
      .MAX_ROW_SAMPLES (MAX_ROW_SAMPLES),
      .MAX_ROWS        (MAX_ROWS),
      .SUM_W           (SUM_W),
      .ACC_W           (ACC_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .has_pixel         (req_tuser[0]),
      .pixel_luma        (req_tdata[7:0]),
      .pixel_blue_chroma (req_tdata[15:8]),
      .pixel_red_chroma  (req_tdata[23:16]),
      .row_end           (req_tuser[1]),
      .rsp_team          (team),
      .rsp_overflow      (rsp_tuser)
   );

   assign rsp_tdata = {6'b0, team};

   a_no_accept_while_dividing: assert property (
      @(posedge clock) disable iff (reset) cmd.step |-> !req_tready)
      else $error("request accepted while the divider runs");

   a_region_end_loads: assert property (
      @(posedge clock) disable iff (reset) (cmd.accept && req_tlast) |=> cmd.load)
      else $error("region end did not start the divider");

   a_load_then_step: assert property (
      @(posedge clock) disable iff (reset) cmd.load |=> cmd.step)
      else $error("divider load not followed by a step");

   a_finish_sets_valid: assert property (
      @(posedge clock) disable iff (reset) cmd.finish |=> rsp_tvalid)
      else $error("verdict written without a valid response");

endmodule

`default_nettype wire

FILE: hw/rtl/tcfc_ctrl.sv
// ----------------------------------------------------------------------------
// tcfc_ctrl: sequencing controller
// Accepts requests, runs the divider at region end and hands the verdict to
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfc_ctrl #(
   parameter int DIV_STEPS = 29
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_region_end,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output tcfc_pkg::cmd_type     cmd
);
   import tcfc_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff;
   logic              req_tready_ff;
   logic              rsp_tvalid_ff;

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd.accept = req_tvalid && req_tready_ff;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.step   = (state_ff == ST_DIVIDE);
      cmd.finish = (state_ff == ST_FINISH) && (!rsp_tvalid_ff || rsp_tready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (cmd.accept && req_region_end) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.finish) begin
               state_in = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACCEPT;
         step_ff       <= '0;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         req_tready_ff <= (state_in == ST_ACCEPT);
         if (state_ff == ST_DIVIDE) begin
            step_ff <= step_ff + 1'b1;
         end else begin
            step_ff <= '0;
         end
         if (cmd.finish) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/tcfc_datapath.sv
// ----------------------------------------------------------------------------
// tcfc_datapath: chroma sums, row minima, maxima and mean divider
// Holds the region state, a restoring divider and the verdict register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfc_datapath #(
   parameter int MAX_ROW_SAMPLES = 64,
   parameter int MAX_ROWS        = 64,
   parameter int SUM_W           = 21,
   parameter int ACC_W           = 29
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcfc_pkg::cmd_type cmd,
   input  wire logic              has_pixel,
   input  wire logic [7:0]        pixel_luma,
   input  wire logic [7:0]        pixel_blue_chroma,
   input  wire logic [7:0]        pixel_red_chroma,
   input  wire logic              row_end,
   output logic [1:0]             rsp_team,
   output logic                   rsp_overflow
);
   import tcfc_pkg::*;

   localparam int SCNT_W = $clog2(MAX_ROW_SAMPLES + 1);
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int REM_W  = RCNT_W + 1;
   localparam int SCORE_W = ACC_W + 2;

   logic signed [SUM_W-1:0] row_blue_ff, row_red_ff;
   logic signed [SUM_W-1:0] prev_blue_ff, prev_red_ff;
   logic signed [SUM_W-1:0] max_blue_ff, max_red_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [RCNT_W-1:0]       row_cnt_ff;
   logic [SCNT_W-1:0]       sample_cnt_ff;
   logic                    overflow_ff;

   logic [ACC_W-1:0]        quot_ff;
   logic [REM_W-1:0]        rem_ff;
   logic                    neg_ff;
   logic [1:0]              team_ff;
   logic                    rsp_overflow_ff;

   logic signed [PIX_W-1:0] luma_s, cb_s, cr_s, px_blue, px_red;
   logic signed [SUM_W-1:0] cur_blue, cur_red, lo_blue, lo_red;
   logic                    row_full, rows_full, take_px, close_row, close_ok;
   logic [REM_W-1:0]        trial;
   logic                    trial_fits;
   logic signed [SUM_W:0]   max_diff;
   logic signed [SCORE_W-1:0] score;
   logic [1:0]              team_in;

   assign rsp_team     = team_ff;
   assign rsp_overflow = rsp_overflow_ff;

   always_comb begin
      luma_s  = $signed({7'b0, pixel_luma});
      cb_s    = $signed({7'b0, pixel_blue_chroma});
      cr_s    = $signed({7'b0, pixel_red_chroma});
      px_blue = W_BLUE_Y * luma_s + W_BLUE_CB * cb_s + W_BLUE_CR * cr_s;
      px_red  = W_RED_Y * luma_s + W_RED_CB * cb_s + W_RED_CR * cr_s;

      row_full  = (sample_cnt_ff == SCNT_W'(MAX_ROW_SAMPLES));
      rows_full = (row_cnt_ff == RCNT_W'(MAX_ROWS));
      take_px   = cmd.accept && has_pixel && !row_full;
      close_row = cmd.accept && row_end;
      close_ok  = close_row && !rows_full;

      cur_blue = take_px ? row_blue_ff + SUM_W'(px_blue) : row_blue_ff;
      cur_red  = take_px ? row_red_ff + SUM_W'(px_red) : row_red_ff;
      lo_blue  = (prev_blue_ff < cur_blue) ? prev_blue_ff : cur_blue;
      lo_red   = (prev_red_ff < cur_red) ? prev_red_ff : cur_red;

      trial      = {rem_ff[REM_W-2:0], quot_ff[ACC_W-1]};
      trial_fits = (trial >= {1'b0, row_cnt_ff});

      max_diff = (SUM_W + 1)'(max_blue_ff) - (SUM_W + 1)'(max_red_ff);
      if (neg_ff) begin
         score = SCORE_W'(max_diff) + $signed({2'b0, quot_ff});
      end else begin
         score = SCORE_W'(max_diff) - $signed({2'b0, quot_ff});
      end
      if (row_cnt_ff == '0) begin
         team_in = TEAM_NONE;
      end else if (score > 0) begin
         team_in = TEAM_BLUE;
      end else begin
         team_in = TEAM_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         row_blue_ff   <= '0;
         row_red_ff    <= '0;
         prev_blue_ff  <= '0;
         prev_red_ff   <= '0;
         max_blue_ff   <= '0;
         max_red_ff    <= '0;
         acc_ff        <= '0;
         row_cnt_ff    <= '0;
         sample_cnt_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         if ((cmd.accept && has_pixel && row_full) || (close_row && rows_full)) begin
            overflow_ff <= 1'b1;
         end
         if (close_row) begin
            row_blue_ff   <= '0;
            row_red_ff    <= '0;
            sample_cnt_ff <= '0;
            if (close_ok) begin
               acc_ff       <= acc_ff + ACC_W'(lo_blue) - ACC_W'(lo_red);
               row_cnt_ff   <= row_cnt_ff + 1'b1;
               prev_blue_ff <= cur_blue;
               prev_red_ff  <= cur_red;
               if (lo_blue > max_blue_ff) begin
                  max_blue_ff <= lo_blue;
               end
               if (lo_red > max_red_ff) begin
                  max_red_ff <= lo_red;
               end
            end
         end else if (take_px) begin
            row_blue_ff   <= cur_blue;
            row_red_ff    <= cur_red;
            sample_cnt_ff <= sample_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff  <= acc_ff[ACC_W-1];
         quot_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         rem_ff  <= '0;
      end else if (cmd.step) begin
         quot_ff <= {quot_ff[ACC_W-2:0], trial_fits};
         rem_ff  <= trial_fits ? trial - {1'b0, row_cnt_ff} : trial;
      end
      if (cmd.finish) begin
         team_ff         <= team_in;
         rsp_overflow_ff <= overflow_ff;
      end
   end

endmodule

`default_nettype wire
